### design/quaternion_to_euler_angles_assert.svh
// Assertion macros for the quaternion to Euler angle converter.
`ifndef QUATERNION_TO_EULER_ANGLES_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define QTE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("quaternion_to_euler_angles check failed");

// Next-cycle implication, checked out of reset.
`define QTE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("quaternion_to_euler_angles check failed");

`endif

### design/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg
// Types, constants and CORDIC helpers for the quaternion to Euler converter.
// ----------------------------------------------------------------------------
`default_nettype none
package qte_pkg;

  localparam int QUAT_WIDTH_DEF    = 16;
  localparam int ANGLE_WIDTH_DEF   = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  // internal formats: components Q2.14, products scale 2^28, angles scale 2^24
  localparam int Q_W   = 16;
  localparam int P_W   = 32;
  localparam int A_W   = 35;
  localparam int S_W   = 29;
  localparam int SQ_W  = 58;
  localparam int SQN   = 29;
  localparam int X_W   = 38;
  localparam int Z_W   = 28;
  localparam int ZFRAC = 24;

  localparam logic signed [Z_W-1:0] PI_Z      = 28'sd52707179;
  localparam logic signed [Z_W-1:0] HALF_PI_Z = 28'sd26353589;
  localparam logic signed [A_W-1:0] ONE_A     = 35'sd268435456;

  localparam int LN_ROLL  = 0;
  localparam int LN_YAW   = 1;
  localparam int LN_PITCH = 2;
  localparam int LANES    = 3;

  typedef struct packed {
    logic signed [X_W-1:0] x;
    logic signed [X_W-1:0] y;
    logic signed [Z_W-1:0] z;
  } lane_t;

  function automatic logic signed [Z_W-1:0] atan_z(logic [4:0] i);
    logic signed [Z_W-1:0] r;
    case (i)
      5'd0:  r = 28'sd13176795;
      5'd1:  r = 28'sd7778716;
      5'd2:  r = 28'sd4110060;
      5'd3:  r = 28'sd2086331;
      5'd4:  r = 28'sd1047214;
      5'd5:  r = 28'sd524117;
      5'd6:  r = 28'sd262123;
      5'd7:  r = 28'sd131069;
      5'd8:  r = 28'sd65536;
      5'd9:  r = 28'sd32768;
      5'd10: r = 28'sd16384;
      5'd11: r = 28'sd8192;
      5'd12: r = 28'sd4096;
      5'd13: r = 28'sd2048;
      5'd14: r = 28'sd1024;
      5'd15: r = 28'sd512;
      5'd16: r = 28'sd256;
      5'd17: r = 28'sd128;
      5'd18: r = 28'sd64;
      5'd19: r = 28'sd32;
      5'd20: r = 28'sd16;
      5'd21: r = 28'sd8;
      5'd22: r = 28'sd4;
      5'd23: r = 28'sd2;
      5'd24: r = 28'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  // fold the left half-plane onto the right one
  function automatic lane_t lane_init(logic signed [X_W-1:0] x, logic signed [X_W-1:0] y);
    lane_t r;
    r.x = x;
    r.y = y;
    r.z = '0;
    if (x < 0) begin
      r.z = (y >= 0) ? PI_Z : -PI_Z;
      r.x = -x;
      r.y = -y;
    end
    return r;
  endfunction

  function automatic lane_t cordic_step(lane_t a, logic [4:0] i);
    lane_t r;
    logic signed [X_W-1:0] xs;
    logic signed [X_W-1:0] ys;
    xs = a.x >>> i;
    ys = a.y >>> i;
    r  = a;
    if (a.y > 0) begin
      r.x = a.x + ys;
      r.y = a.y - xs;
      r.z = a.z + atan_z(i);
    end else begin
      r.x = a.x - ys;
      r.y = a.y + xs;
      r.z = a.z - atan_z(i);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### design/quaternion_to_euler_angles.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// ZYX Euler angles from a unit quaternion through pipelined CORDIC.
// ----------------------------------------------------------------------------
// One quaternion word is taken in every cycle (busy stays low) and its angles
// appear on the out_ ports, strobed by out_valid, after passing through the
// 29-step bit-per-stage square root that feeds the pitch arctangent and the
// unrolled CORDIC, one stage per iteration. Results come out in input order
// and cannot be held off.
`default_nettype none
`include "quaternion_to_euler_angles_assert.svh"
module quaternion_to_euler_angles #(
  parameter int QUAT_WIDTH    = qte_pkg::QUAT_WIDTH_DEF,
  parameter int ANGLE_WIDTH   = qte_pkg::ANGLE_WIDTH_DEF,
  parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [QUAT_WIDTH-1:0]  in_quat_w,
  input  wire logic signed [QUAT_WIDTH-1:0]  in_quat_x,
  input  wire logic signed [QUAT_WIDTH-1:0]  in_quat_y,
  input  wire logic signed [QUAT_WIDTH-1:0]  in_quat_z,
  output logic                               out_valid,
  output logic signed [ANGLE_WIDTH-1:0]      out_roll_angle,
  output logic signed [ANGLE_WIDTH-2:0]      out_pitch_angle,
  output logic signed [ANGLE_WIDTH-1:0]      out_yaw_angle,
  output logic                               out_pitch_clamped
);
  import qte_pkg::*;

  localparam int DN   = (QUAT_WIDTH > Q_W) ? QUAT_WIDTH - Q_W : 0;
  localparam int UP   = (QUAT_WIDTH < Q_W) ? Q_W - QUAT_WIDTH : 0;
  localparam int AF   = ANGLE_WIDTH - 3;
  localparam int SH_R = (AF < ZFRAC) ? ZFRAC - AF : 0;
  localparam int SH_L = (AF < ZFRAC) ? 0 : AF - ZFRAC;
  localparam int R_W  = 40;
  localparam int LAT  = 36 + CORDIC_STAGES;

  localparam logic signed [R_W-1:0] RND = (SH_R > 0) ?
    (40'sd1 <<< ((SH_R > 0) ? SH_R - 1 : 0)) : 40'sd0;
  localparam logic signed [R_W-1:0] PI_LIM   = ((R_W'(PI_Z) + RND) >>> SH_R) <<< SH_L;
  localparam logic signed [R_W-1:0] HALF_LIM = ((R_W'(HALF_PI_Z) + RND) >>> SH_R) <<< SH_L;
  localparam logic [SQ_W-1:0] SQ_ONE = 58'd1 << 56;

  function automatic logic signed [Q_W-1:0] to_q14(logic signed [QUAT_WIDTH-1:0] v);
    logic signed [47:0] t;
    t = 48'(v);
    return Q_W'((t >>> DN) <<< UP);
  endfunction

  function automatic logic signed [R_W-1:0] rescale(logic signed [Z_W-1:0] z);
    return ((R_W'(z) + RND) >>> SH_R) <<< SH_L;
  endfunction

  logic [LAT-1:0] vld_r;

  logic signed [Q_W-1:0] qw_r, qx_r, qy_r, qz_r;
  logic signed [P_W-1:0] xw_r, yz_r, xy_r, zw_r, yw_r, xz_r, xx_r, yy_r, zz_r;
  logic signed [A_W-1:0] ra_r, rb_r, ya_r, yb_r, s_r;
  logic                  cl2_r;
  logic [SQ_W-1:0]       sq_r;
  logic signed [S_W-1:0] s3_r;
  logic                  cl3_r;
  lane_t                 rl3_r, yl3_r;

  logic [SQ_W-1:0]       n_r   [0:SQN];
  logic [SQ_W-1:0]       res_r [0:SQN];
  lane_t                 rl_r  [0:SQN];
  lane_t                 yl_r  [0:SQN];
  logic signed [S_W-1:0] sd_r  [0:SQN];
  logic                  cl_r  [0:SQN];

  lane_t                 ln_r  [0:CORDIC_STAGES][LANES];
  logic                  clc_r [0:CORDIC_STAGES];
  logic                  sgc_r [0:CORDIC_STAGES];

  logic signed [R_W-1:0] roll_s, yaw_s, pitch_s;
  logic signed [R_W-1:0] roll_nxt, yaw_nxt, pitch_nxt;
  logic signed [ANGLE_WIDTH-1:0] roll_r, yaw_r;
  logic signed [ANGLE_WIDTH-2:0] pitch_r;
  logic                          clamp_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], start & ~busy};
    end
  end

  // front end: normalise, multiply, sum, square
  always_ff @(posedge clk) begin
    qw_r <= to_q14(in_quat_w);
    qx_r <= to_q14(in_quat_x);
    qy_r <= to_q14(in_quat_y);
    qz_r <= to_q14(in_quat_z);

    xw_r <= qx_r * qw_r;
    yz_r <= qy_r * qz_r;
    xy_r <= qx_r * qy_r;
    zw_r <= qz_r * qw_r;
    yw_r <= qy_r * qw_r;
    xz_r <= qx_r * qz_r;
    xx_r <= qx_r * qx_r;
    yy_r <= qy_r * qy_r;
    zz_r <= qz_r * qz_r;

    ra_r  <= (A_W'(xw_r) + A_W'(yz_r)) <<< 1;
    rb_r  <= ONE_A - ((A_W'(xx_r) + A_W'(yy_r)) <<< 1);
    ya_r  <= (A_W'(xy_r) + A_W'(zw_r)) <<< 1;
    yb_r  <= ONE_A - ((A_W'(yy_r) + A_W'(zz_r)) <<< 1);
    s_r   <= (A_W'(yw_r) - A_W'(xz_r)) <<< 1;
    cl2_r <= ((A_W'(yw_r) - A_W'(xz_r)) <<< 1) >= ONE_A ||
             ((A_W'(yw_r) - A_W'(xz_r)) <<< 1) <= -ONE_A;

    // s fits in S_W bits whenever it is not clamped; hold only the sign otherwise
    sq_r  <= SQ_W'($signed(s_r[S_W-1:0]) * $signed(s_r[S_W-1:0]));
    s3_r  <= cl2_r ? {s_r[A_W-1], {(S_W-1){~s_r[A_W-1]}}} : s_r[S_W-1:0];
    cl3_r <= cl2_r;
    rl3_r <= lane_init(X_W'(rb_r), X_W'(ra_r));
    yl3_r <= lane_init(X_W'(yb_r), X_W'(ya_r));

    n_r[0]   <= SQ_ONE - sq_r;
    res_r[0] <= '0;
    rl_r[0]  <= rl3_r;
    yl_r[0]  <= yl3_r;
    sd_r[0]  <= s3_r;
    cl_r[0]  <= cl3_r;
  end

  // square root, one result bit per stage
  for (genvar k = 0; k < SQN; k++) begin : g_sqrt
    localparam logic [SQ_W-1:0] BITK = 58'd1 << (56 - 2 * k);
    logic [SQ_W-1:0] trial;
    assign trial = res_r[k] + BITK;
    always_ff @(posedge clk) begin
      if (n_r[k] >= trial) begin
        n_r[k+1]   <= n_r[k] - trial;
        res_r[k+1] <= (res_r[k] >> 1) + BITK;
      end else begin
        n_r[k+1]   <= n_r[k];
        res_r[k+1] <= res_r[k] >> 1;
      end
      rl_r[k+1] <= rl_r[k];
      yl_r[k+1] <= yl_r[k];
      sd_r[k+1] <= sd_r[k];
      cl_r[k+1] <= cl_r[k];
    end
  end

  always_ff @(posedge clk) begin
    ln_r[0][LN_ROLL]  <= rl_r[SQN];
    ln_r[0][LN_YAW]   <= yl_r[SQN];
    ln_r[0][LN_PITCH] <= lane_init(X_W'(res_r[SQN][S_W-1:0]), X_W'(sd_r[SQN]));
    clc_r[0]          <= cl_r[SQN];
    sgc_r[0]          <= sd_r[SQN] > 0;
  end

  for (genvar j = 0; j < CORDIC_STAGES; j++) begin : g_cordic
    always_ff @(posedge clk) begin
      for (int l = 0; l < LANES; l++) begin
        ln_r[j+1][l] <= cordic_step(ln_r[j][l], 5'(j));
      end
      clc_r[j+1] <= clc_r[j];
      sgc_r[j+1] <= sgc_r[j];
    end
  end

  // round to the output scale and saturate
  always_comb begin
    roll_s  = rescale(ln_r[CORDIC_STAGES][LN_ROLL].z);
    yaw_s   = rescale(ln_r[CORDIC_STAGES][LN_YAW].z);
    pitch_s = rescale(ln_r[CORDIC_STAGES][LN_PITCH].z);
    roll_nxt = (roll_s > PI_LIM) ? PI_LIM : ((roll_s < -PI_LIM) ? -PI_LIM : roll_s);
    yaw_nxt  = (yaw_s > PI_LIM) ? PI_LIM : ((yaw_s < -PI_LIM) ? -PI_LIM : yaw_s);
    if (clc_r[CORDIC_STAGES]) begin
      pitch_nxt = sgc_r[CORDIC_STAGES] ? HALF_LIM : -HALF_LIM;
    end else begin
      pitch_nxt = (pitch_s > HALF_LIM) ? HALF_LIM :
                  ((pitch_s < -HALF_LIM) ? -HALF_LIM : pitch_s);
    end
  end

  always_ff @(posedge clk) begin
    roll_r  <= ANGLE_WIDTH'(roll_nxt);
    yaw_r   <= ANGLE_WIDTH'(yaw_nxt);
    pitch_r <= (ANGLE_WIDTH - 1)'(pitch_nxt);
    clamp_r <= clc_r[CORDIC_STAGES];
  end

  assign out_valid         = vld_r[LAT-1];
  assign out_roll_angle    = roll_r;
  assign out_yaw_angle     = yaw_r;
  assign out_pitch_angle   = pitch_r;
  assign out_pitch_clamped = clamp_r;

  `QTE_ASSERT_IMP(a_clamp_half_pi, out_valid && out_pitch_clamped,
    R_W'(out_pitch_angle) == HALF_LIM || R_W'(out_pitch_angle) == -HALF_LIM)
  `QTE_ASSERT_IMP(a_pitch_range, out_valid,
    R_W'(out_pitch_angle) <= HALF_LIM && R_W'(out_pitch_angle) >= -HALF_LIM)
  `QTE_ASSERT_IMP(a_roll_yaw_range, out_valid,
    R_W'(out_roll_angle) <= PI_LIM && R_W'(out_roll_angle) >= -PI_LIM &&
    R_W'(out_yaw_angle) <= PI_LIM && R_W'(out_yaw_angle) >= -PI_LIM)
  `QTE_ASSERT_NXT(a_accept_tracked, start && !busy, vld_r[0])

endmodule
`default_nettype wire

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the quaternion to Euler angle converter.
// ----------------------------------------------------------------------------
// Directed quaternions (identity, axis extremes, gimbal lock, the pi fold)
// are followed by random unit quaternions, near-lock words and raw in-range words. They are
// sent in bursts with random gaps. Every accepted word is run through a local
// CORDIC predictor. Each strobed result is checked against the oldest
// expected angle set.
`default_nettype none
module tb_top;

  localparam int     NUM_RANDOM = 1100;
  localparam int     LIMIT      = 200000;
  localparam int     DRAIN      = 120;
  localparam longint PI_ZS      = 52707179;
  localparam longint HALF_PI_ZS = 26353589;
  localparam longint ONE_P      = longint'(1) << 28;

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat_t;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
    logic               clamped;
  } euler_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic signed [15:0] in_quat_w, in_quat_x, in_quat_y, in_quat_z;
  logic out_valid;
  logic signed [15:0] out_roll_angle;
  logic signed [14:0] out_pitch_angle;
  logic signed [15:0] out_yaw_angle;
  logic out_pitch_clamped;

  quat_t  pending_quats[$];
  euler_t expected_angles[$];
  bit     taken;
  bit     failed;
  int     burst_left;
  int     gap_left;
  int     cycle_count;

  quaternion_to_euler_angles u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_quat_w(in_quat_w), .in_quat_x(in_quat_x),
    .in_quat_y(in_quat_y), .in_quat_z(in_quat_z),
    .out_valid(out_valid), .out_roll_angle(out_roll_angle),
    .out_pitch_angle(out_pitch_angle), .out_yaw_angle(out_yaw_angle),
    .out_pitch_clamped(out_pitch_clamped)
  );

  function automatic longint atan_step(int i);
    longint tab[25] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
                        262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048,
                        1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1};
    return (i < 25) ? tab[i] : 0;
  endfunction

  function automatic longint vector_angle(longint ya, longint xa);
    longint zacc;
    longint xs;
    longint ys;
    zacc = 0;
    if (xa < 0) begin
      zacc = (ya >= 0) ? PI_ZS : -PI_ZS;
      xa = -xa;
      ya = -ya;
    end
    for (int i = 0; i < 16; i++) begin
      xs = xa >>> i;
      ys = ya >>> i;
      if (ya > 0) begin
        xa += ys;
        ya -= xs;
        zacc += atan_step(i);
      end else begin
        xa -= ys;
        ya += xs;
        zacc -= atan_step(i);
      end
    end
    return zacc;
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  // round to 13 fraction bits and saturate at the given limit
  function automatic longint to_angle(longint zacc, longint lim_z);
    longint r;
    longint lim;
    r = (zacc + 1024) >>> 11;
    lim = (lim_z + 1024) >>> 11;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic euler_t euler_of(quat_t q);
    euler_t e;
    longint w, x, y, z, s, c;
    w = q.w; x = q.x; y = q.y; z = q.z;
    e.roll = 16'(to_angle(vector_angle(2 * (x * w + y * z),
                                       ONE_P - 2 * (x * x + y * y)), PI_ZS));
    e.yaw  = 16'(to_angle(vector_angle(2 * (x * y + z * w),
                                       ONE_P - 2 * (y * y + z * z)), PI_ZS));
    s = 2 * (y * w - x * z);
    if (s >= ONE_P || s <= -ONE_P) begin
      e.clamped = 1'b1;
      e.pitch = 15'(to_angle(s > 0 ? HALF_PI_ZS : -HALF_PI_ZS, HALF_PI_ZS));
    end else begin
      e.clamped = 1'b0;
      c = int_sqrt((64'd1 << 56) - longint'(s * s));
      e.pitch = 15'(to_angle(vector_angle(s, c), HALF_PI_ZS));
    end
    return e;
  endfunction

  function automatic quat_t mk(int w, int x, int y, int z);
    quat_t q;
    q.w = 16'(w); q.x = 16'(x); q.y = 16'(y); q.z = 16'(z);
    return q;
  endfunction

  function automatic int rnd_comp();
    return $urandom_range(32768) - 16384;
  endfunction

  function automatic quat_t rnd_unit();
    real a[4];
    real n;
    n = 0.0;
    for (int i = 0; i < 4; i++) begin
      a[i] = real'(rnd_comp());
      n += a[i] * a[i];
    end
    if (n < 1.0) return mk(16384, 0, 0, 0);
    n = $sqrt(n);
    return mk($rtoi(a[0] * 16384.0 / n), $rtoi(a[1] * 16384.0 / n),
              $rtoi(a[2] * 16384.0 / n), $rtoi(a[3] * 16384.0 / n));
  endfunction

  initial clk = 1'b0;

  always #4 clk = ~clk;

  initial begin
    int mode;
    int c;
    rst_n = 1'b0;
    start = 1'b0;
    in_quat_w = '0; in_quat_x = '0; in_quat_y = '0; in_quat_z = '0;
    pending_quats.push_back(mk(16384, 0, 0, 0));
    pending_quats.push_back(mk(0, 0, 0, 0));
    pending_quats.push_back(mk(-16384, 0, 0, 0));
    pending_quats.push_back(mk(0, 16384, 0, 0));    // roll folds to pi
    pending_quats.push_back(mk(0, 0, 0, 16384));    // yaw folds to pi
    pending_quats.push_back(mk(0, 0, 16384, 0));
    pending_quats.push_back(mk(0, -16384, 0, 0));
    pending_quats.push_back(mk(11586, 0, 11586, 0));   // gimbal lock, positive
    pending_quats.push_back(mk(11586, 0, -11586, 0));  // gimbal lock, negative
    pending_quats.push_back(mk(11585, 0, 11585, 0));   // just below lock
    pending_quats.push_back(mk(0, 11586, 0, -11586));
    pending_quats.push_back(mk(16384, 16384, 16384, 16384));
    pending_quats.push_back(mk(-16384, -16384, -16384, -16384));
    pending_quats.push_back(mk(16384, -16384, 16384, -16384));
    pending_quats.push_back(mk(8192, 8192, 8192, 8192));
    pending_quats.push_back(mk(-1, -1, -1, -1));
    pending_quats.push_back(mk(1, 0, 0, 0));
    pending_quats.push_back(mk(11585, 11585, 0, 0));
    pending_quats.push_back(mk(11585, 0, 0, -11585));
    pending_quats.push_back(mk(0, 0, 11585, 11585));
    for (int n = 0; n < NUM_RANDOM; n++) begin
      mode = $urandom_range(9);
      if (mode < 7) begin
        pending_quats.push_back(rnd_unit());
      end else if (mode == 7) begin
        // near gimbal lock: w and y alike, x and z small
        c = $urandom_range(400);
        pending_quats.push_back(mk(11400 + c, $urandom_range(64) - 32,
                                   ($urandom_range(1) ? 1 : -1) * (11400 + $urandom_range(400)),
                                   $urandom_range(64) - 32));
      end else begin
        pending_quats.push_back(mk(rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp()));
      end
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_quats.size() == 0 && !start);
    wait (expected_angles.size() == 0);
    repeat (DRAIN) @(posedge clk);
    if (!failed && expected_angles.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // drive on the falling edge, in bursts with gaps
  always @(negedge clk) begin
    quat_t q;
    if (rst_n && (!start || taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_quats.size() > 0) begin
        q = pending_quats.pop_front();
        in_quat_w <= q.w; in_quat_x <= q.x; in_quat_y <= q.y; in_quat_z <= q.z;
        start <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(40);
          gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
        end else begin
          burst_left--;
        end
      end else begin
        start <= 1'b0;
      end
    end
    taken = 1'b0;
  end

  // accept words and check results on the rising edge
  always @(posedge clk) begin
    euler_t e;
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("tb_top failed");
      $finish;
    end else if (rst_n) begin
      if (out_valid) begin
        if (expected_angles.size() == 0) begin
          $display("%0t: unexpected result roll %0d pitch %0d yaw %0d", $time,
                   out_roll_angle, out_pitch_angle, out_yaw_angle);
          failed = 1'b1;
        end else begin
          e = expected_angles.pop_front();
          if (out_roll_angle !== e.roll) begin
            $display("%0t: roll expected %0d actual %0d", $time, e.roll, out_roll_angle);
            failed = 1'b1;
          end
          if (out_pitch_angle !== e.pitch) begin
            $display("%0t: pitch expected %0d actual %0d", $time, e.pitch, out_pitch_angle);
            failed = 1'b1;
          end
          if (out_yaw_angle !== e.yaw) begin
            $display("%0t: yaw expected %0d actual %0d", $time, e.yaw, out_yaw_angle);
            failed = 1'b1;
          end
          if (out_pitch_clamped !== e.clamped) begin
            $display("%0t: clamp expected %0d actual %0d", $time, e.clamped,
                     out_pitch_clamped);
            failed = 1'b1;
          end
        end
      end
      if (start && !busy) begin
        expected_angles.push_back(euler_of(mk(in_quat_w, in_quat_x, in_quat_y, in_quat_z)));
        taken = 1'b1;
      end
    end
  end

endmodule
`default_nettype wire
